@@ design/mqes_pkg.sv @@
// ----------------------------------------------------------------------------
// Multi-encoder quadrature stepper package
// Shared sizes, the quadrature transition table and the step-multiple mask.
// ----------------------------------------------------------------------------
`default_nettype none

package mqes_pkg;

   // Number of encoders tracked. The 5-bit index port addresses up to 32.
   localparam int ENCODER_COUNT = 32;
   localparam int ENC_IDX_W     = (ENCODER_COUNT > 1) ? $clog2(ENCODER_COUNT) : 1;

   // Pulses per reported step.
   localparam int STEP_PULSES = 4;

   // Field widths.
   localparam int INDEX_W = 5;
   localparam int PAIR_W  = 2;
   localparam int COUNT_W = 4;
   localparam int MOVE_W  = 2;

   // Pulse count value after reset and after each reported step.
   localparam logic [COUNT_W-1:0] PULSE_RESET = 4'd8;

   // Movement codes.
   localparam logic signed [MOVE_W-1:0] MOVE_NONE = 2'sd0;
   localparam logic signed [MOVE_W-1:0] MOVE_POS  = 2'sd1;
   localparam logic signed [MOVE_W-1:0] MOVE_NEG  = -2'sd1;

   typedef logic signed [MOVE_W-1:0] move_type;

   // Per-encoder state entry.
   typedef struct packed {
      logic [PAIR_W-1:0]  prev_pair;
      logic [COUNT_W-1:0] pulse_count;
      logic               last_dir;   // 1 positive, 0 negative
   } enc_state_type;

   // Quadrature transition table, indexed by {previous pair, current pair}.
   localparam move_type QUAD_TABLE [16] = '{
      MOVE_NONE, MOVE_NEG,  MOVE_POS,  MOVE_NONE,
      MOVE_POS,  MOVE_NONE, MOVE_NONE, MOVE_NEG,
      MOVE_NEG,  MOVE_NONE, MOVE_NONE, MOVE_POS,
      MOVE_NONE, MOVE_POS,  MOVE_NEG,  MOVE_NONE
   };

   // Bit k is set when count value k is a multiple of STEP_PULSES.
   function automatic logic [15:0] step_mult_mask();
      logic [15:0] mask;
      mask = '0;
      for (int k = 0; k < 16; k++) begin
         mask[k] = ((k % STEP_PULSES) == 0);
      end
      return mask;
   endfunction

   localparam logic [15:0] STEP_MULT_MASK = step_mult_mask();

endpackage

`default_nettype wire

@@ design/multi_quadrature_encoder_stepper_core.sv @@
// ----------------------------------------------------------------------------
// Multi-encoder quadrature stepper core
// Decodes A/B samples of up to 32 encoders into single step movements.
// ----------------------------------------------------------------------------
// Each item carries one encoder's index and its current A/B levels and
// produces exactly one movement item (0, +1 or -1). An item is registered on
// entry; from the input register its encoder's state entry is read, updated
// and written back while the movement is captured in the output register.
// One item is taken every cycle while the output is not stalled. Items for
// the same encoder may follow each other directly, since the state is read
// and written in the same stage. Indices at or above the encoder count leave
// all state untouched and report no movement. State resets to pair 0, count 8
// and negative direction at once, so no clearing pass is needed.
`default_nettype none

module multi_quadrature_encoder_stepper_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [mqes_pkg::INDEX_W-1:0]       req_encoder_index,
   input  wire logic [mqes_pkg::PAIR_W-1:0]        req_ab_pair,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [mqes_pkg::MOVE_W-1:0]      rsp_movement
);

   // Input register.
   logic                               s1_valid_ff;
   logic [mqes_pkg::INDEX_W-1:0]       s1_index_ff;
   logic [mqes_pkg::PAIR_W-1:0]        s1_pair_ff;

   // Output register.
   logic                               out_valid_ff;
   mqes_pkg::move_type                 out_move_ff;
   mqes_pkg::move_type                 out_move_in;

   // Per-encoder state.
   mqes_pkg::enc_state_type            state_ff [mqes_pkg::ENCODER_COUNT];
   mqes_pkg::enc_state_type            entry;
   mqes_pkg::enc_state_type            entry_in;

   logic                               out_ready;
   logic                               advance;
   logic                               in_range;
   logic [mqes_pkg::ENC_IDX_W-1:0]     sel;
   logic [3:0]                         tindex;
   mqes_pkg::move_type                 delta;
   logic                               new_dir;
   logic [mqes_pkg::COUNT_W-1:0]       count;

   // Handshake: the output register frees up when empty or being taken.
   assign out_ready = !out_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_ready;
   assign req_stall = s1_valid_ff && !out_ready;

   assign rsp_valid    = out_valid_ff;
   assign rsp_movement = out_move_ff;

   // Read the addressed encoder's state.
   assign in_range = (32'(s1_index_ff) < mqes_pkg::ENCODER_COUNT);
   assign sel      = s1_index_ff[mqes_pkg::ENC_IDX_W-1:0];
   assign entry    = state_ff[sel];

   // Transition decode and count update.
   always_comb begin
      tindex      = {entry.prev_pair, s1_pair_ff};
      delta       = mqes_pkg::QUAD_TABLE[tindex];
      new_dir     = (delta == mqes_pkg::MOVE_POS);
      count       = new_dir ? (entry.pulse_count + 4'd1) : (entry.pulse_count - 4'd1);
      entry_in    = entry;
      out_move_in = mqes_pkg::MOVE_NONE;
      entry_in.prev_pair = s1_pair_ff;
      if (delta != mqes_pkg::MOVE_NONE) begin
         entry_in.pulse_count = count;
         entry_in.last_dir    = new_dir;
         if ((entry.last_dir == new_dir) && mqes_pkg::STEP_MULT_MASK[count]) begin
            entry_in.pulse_count = mqes_pkg::PULSE_RESET;
            out_move_in          = new_dir ? mqes_pkg::MOVE_POS : mqes_pkg::MOVE_NEG;
         end
      end
      if (!in_range) begin
         out_move_in = mqes_pkg::MOVE_NONE;
      end
   end

   // Input register control.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_index_ff <= req_encoder_index;
         s1_pair_ff  <= req_ab_pair;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_move_ff <= out_move_in;
      end
   end

   // State write-back.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mqes_pkg::ENCODER_COUNT; i++) begin
            state_ff[i] <= '{prev_pair:   '0,
                             pulse_count: mqes_pkg::PULSE_RESET,
                             last_dir:    1'b0};
         end
      end else if (advance && in_range) begin
         state_ff[sel] <= entry_in;
      end
   end

endmodule

`default_nettype wire

@@ design/mqes_checker.sv @@
// ----------------------------------------------------------------------------
// Multi-encoder quadrature stepper checker
// Port-level assertions on flow and result coding, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module mqes_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [mqes_pkg::MOVE_W-1:0]   rsp_movement
);

   // A stalled result item holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_movement))
      else $error("stalled result item changed");

   // The movement code is never the unused pattern.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_movement != 2'b10))
      else $error("invalid movement code");

   // The input side stalls only behind a stalled result.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without back-pressure");

   // An accepted item reaches the output register when the output is not held up.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall |=> rsp_valid)
      else $error("accepted item did not reach the output");

   // Nothing is valid straight after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("handshake active after reset");

endmodule

bind multi_quadrature_encoder_stepper_core mqes_checker u_mqes_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_movement      (rsp_movement)
);

`default_nettype wire

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// Multi-encoder quadrature stepper testbench
// Sends A/B samples to the stepper core, predicts each movement from a model
// of every encoder's state kept here, and checks each returned item against
// it in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 12;
   localparam int RANDOM_ITEMS   = 1525;

   // Step of each transition, indexed by {previous pair, current pair}.
   localparam logic signed [1:0] PULSE_STEP [16] = '{
      2'sd0,  -2'sd1, 2'sd1,  2'sd0,
      2'sd1,  2'sd0,  2'sd0,  -2'sd1,
      -2'sd1, 2'sd0,  2'sd0,  2'sd1,
      2'sd0,  2'sd1,  -2'sd1, 2'sd0
   };

   // Next pair when turning forwards (0, 2, 3, 1) and backwards (0, 1, 3, 2).
   localparam logic [1:0] TURN_FWD [4] = '{2'd2, 2'd0, 2'd3, 2'd1};
   localparam logic [1:0] TURN_REV [4] = '{2'd1, 2'd3, 2'd0, 2'd2};

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [mqes_pkg::INDEX_W-1:0]  req_encoder_index = '0;
   logic [mqes_pkg::PAIR_W-1:0]   req_ab_pair = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   mqes_pkg::move_type            rsp_movement;

   // Tracked state of every encoder.
   logic [mqes_pkg::PAIR_W-1:0]   enc_pair  [mqes_pkg::ENCODER_COUNT];
   logic [mqes_pkg::COUNT_W-1:0]  enc_count [mqes_pkg::ENCODER_COUNT];
   logic                          enc_dir   [mqes_pkg::ENCODER_COUNT];
   bit                            spin_fwd  [mqes_pkg::ENCODER_COUNT];

   mqes_pkg::move_type            pending_moves [$];
   int                            fail_count = 0;
   int                            idle_cycles = 0;
   int                            stall_left = 0;
   bit                            steady = 1'b0;

   multi_quadrature_encoder_stepper_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_encoder_index (req_encoder_index),
      .req_ab_pair       (req_ab_pair),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_movement      (rsp_movement)
   );

   always #6 clock = ~clock;

   // Length of a pause: mostly none or short, now and then long.
   function automatic int pause_len();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Advances one encoder by a sample and returns the movement it reports.
   function automatic mqes_pkg::move_type track_sample(
         logic [mqes_pkg::INDEX_W-1:0] idx, logic [mqes_pkg::PAIR_W-1:0] pair);
      logic signed [1:0]             step;
      logic [mqes_pkg::COUNT_W-1:0]  cnt;
      logic                          dir_now;
      mqes_pkg::move_type            move;
      move = mqes_pkg::MOVE_NONE;
      if (idx < mqes_pkg::ENCODER_COUNT) begin
         step = PULSE_STEP[{enc_pair[idx], pair}];
         enc_pair[idx] = pair;
         if (step != 0) begin
            dir_now = (step > 0);
            cnt = (step > 0) ? enc_count[idx] + 4'd1 : enc_count[idx] - 4'd1;
            enc_count[idx] = cnt;
            if (dir_now == enc_dir[idx] && (int'(cnt) % mqes_pkg::STEP_PULSES) == 0) begin
               enc_count[idx] = mqes_pkg::PULSE_RESET;
               move = dir_now ? mqes_pkg::MOVE_POS : mqes_pkg::MOVE_NEG;
            end
            enc_dir[idx] = dir_now;
         end
      end
      return move;
   endfunction

   // Offers one sample, waits until it is taken and records its movement.
   task automatic send_sample(input logic [mqes_pkg::INDEX_W-1:0] idx,
                              input logic [mqes_pkg::PAIR_W-1:0] pair);
      int gap;
      gap = pause_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_encoder_index <= idx;
      req_ab_pair       <= pair;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_moves.push_back(track_sample(idx, pair));
   endtask

   // A held level and double jumps between opposite pairs.
   task automatic test_idle_and_jumps();
      send_sample(5'd4, 2'd0);
      send_sample(5'd4, 2'd3);
      send_sample(5'd4, 2'd0);
      send_sample(5'd4, 2'd0);
   endtask

   // Two full forward turns on the lowest encoder.
   task automatic test_forward_turns();
      repeat (2) begin
         send_sample(5'd0, 2'd2);
         send_sample(5'd0, 2'd3);
         send_sample(5'd0, 2'd1);
         send_sample(5'd0, 2'd0);
      end
   endtask

   // Two full backward turns on the highest encoder.
   task automatic test_reverse_turns();
      repeat (2) begin
         send_sample(5'd31, 2'd1);
         send_sample(5'd31, 2'd3);
         send_sample(5'd31, 2'd2);
         send_sample(5'd31, 2'd0);
      end
   endtask

   // A turn that reverses twice before it carries on.
   task automatic test_direction_reversal();
      send_sample(5'd2, 2'd2);
      send_sample(5'd2, 2'd0);
      send_sample(5'd2, 2'd2);
      send_sample(5'd2, 2'd3);
      send_sample(5'd2, 2'd1);
   endtask

   // Mostly clean turns on a few busy encoders, with reversals, held levels,
   // double jumps and arbitrary pairs mixed in.
   task automatic test_random_turns();
      logic [mqes_pkg::INDEX_W-1:0] idx;
      logic [mqes_pkg::PAIR_W-1:0]  cur;
      logic [mqes_pkg::PAIR_W-1:0]  pair;
      int                           r;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 150 == 0) steady <= ((n / 150) % 4 == 3);
         if ($urandom_range(0, 3) == 0) idx = 5'($urandom_range(0, 31));
         else begin
            case ($urandom_range(0, 3))
               0: idx = 5'd0;
               1: idx = 5'd9;
               2: idx = 5'd22;
               default: idx = 5'd31;
            endcase
         end
         cur = enc_pair[idx];
         r = $urandom_range(0, 99);
         if (r < 8) spin_fwd[idx] = !spin_fwd[idx];
         if (r < 75) pair = spin_fwd[idx] ? TURN_FWD[cur] : TURN_REV[cur];
         else if (r < 85) pair = cur;
         else if (r < 93) pair = ~cur;
         else pair = 2'($urandom_range(0, 3));
         send_sample(idx, pair);
      end
      steady <= 1'b0;
   endtask

   // Receiver stalls in bursts of random length.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (steady || $urandom_range(0, 99) < 60) begin
         rsp_stall  <= 1'b0;
         stall_left <= $urandom_range(0, 6);
      end else begin
         rsp_stall  <= 1'b1;
         stall_left <= pause_len();
      end
   end

   // Each movement item is checked against the oldest prediction.
   always @(posedge clock) begin
      mqes_pkg::move_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_moves.size() == 0) begin
            $error("movement: expected nothing, got %0d", rsp_movement);
            fail_count++;
         end else begin
            want = pending_moves.pop_front();
            if (rsp_movement !== want) begin
               $error("movement: expected %0d, got %0d", want, rsp_movement);
               fail_count++;
            end
         end
      end
   end

   // Ends the run when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < mqes_pkg::ENCODER_COUNT; i++) begin
         enc_pair[i]  = '0;
         enc_count[i] = mqes_pkg::PULSE_RESET;
         enc_dir[i]   = 1'b0;
         spin_fwd[i]  = ($urandom_range(0, 1) == 1);
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_and_jumps();
      test_forward_turns();
      test_reverse_turns();
      test_direction_reversal();
      test_random_turns();
      req_valid <= 1'b0;

      // Let the last movements drain before reporting the result.
      while (pending_moves.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
